### design/sct_pkg.sv
package sct_pkg;

  // Connection table geometry (power of two entry count)
  localparam int CONN_ENTRIES = 1024;
  localparam int ADDR_W       = $clog2(CONN_ENTRIES);

  // Field widths
  localparam int IDX_W   = 10;
  localparam int DIR_W   = 2;
  localparam int CTYPE_W = 8;
  localparam int CLEN_W  = 16;
  localparam int TMO_W   = 16;
  localparam int CFG_IW  = 2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_TIMEOUT_NONE        = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TIMEOUT_SHORT       = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TIMEOUT_ESTABLISHED = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_TIMEOUT_DEFAULT     = 2'd3;

  // Timeout reset values in seconds
  localparam logic [TMO_W-1:0] TMO_NONE_RST        = TMO_W'(2);
  localparam logic [TMO_W-1:0] TMO_SHORT_RST       = TMO_W'(0 + 3 + 1);
  localparam logic [TMO_W-1:0] TMO_ESTABLISHED_RST = TMO_W'(15 * 60);
  localparam logic [TMO_W-1:0] TMO_DEFAULT_RST     = TMO_W'(60 + 1);

  // Packet direction codes
  localparam logic [DIR_W-1:0] DIR_IN      = 2'd0;
  localparam logic [DIR_W-1:0] DIR_OUT     = 2'd1;
  localparam logic [DIR_W-1:0] DIR_IN_ONLY = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UNUSED  = 2'd3;

  // Chunk type bytes that map to events
  localparam logic [CTYPE_W-1:0] CT_INIT              = 8'd1;
  localparam logic [CTYPE_W-1:0] CT_INIT_ACK          = 8'd2;
  localparam logic [CTYPE_W-1:0] CT_ABORT             = 8'd6;
  localparam logic [CTYPE_W-1:0] CT_SHUTDOWN          = 8'd7;
  localparam logic [CTYPE_W-1:0] CT_SHUTDOWN_ACK      = 8'd8;
  localparam logic [CTYPE_W-1:0] CT_ERROR             = 8'd9;
  localparam logic [CTYPE_W-1:0] CT_COOKIE_ECHO       = 8'd10;
  localparam logic [CTYPE_W-1:0] CT_COOKIE_ACK        = 8'd11;
  localparam logic [CTYPE_W-1:0] CT_SHUTDOWN_COMPLETE = 8'd14;

  // Minimum length of a cookie chunk that may bundle an abort
  localparam logic [CLEN_W-1:0] BUNDLE_MIN_LEN = 16'd4;

  typedef enum logic [3:0] {
    S_NON, S_IN1, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
    S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS
  } state_t;

  typedef enum logic [3:0] {
    EV_DATA, EV_INIT, EV_INIT_ACK, EV_COOKIE_ECHO, EV_COOKIE_ACK,
    EV_SHUTDOWN, EV_SHUTDOWN_ACK, EV_SHUTDOWN_COMPLETE, EV_ERROR, EV_ABORT
  } event_t;

  typedef enum logic [1:0] {
    ACT_NONE, ACT_INACTIVE, ACT_ACTIVE
  } act_t;

  // One connection entry as stored
  typedef struct packed {
    logic   inactive;
    state_t st;
  } entry_t;

  // Captured request
  typedef struct packed {
    logic [IDX_W-1:0]   conn_index;
    logic               start_new;
    logic [DIR_W-1:0]   direction;
    logic               chunk_valid;
    logic [CTYPE_W-1:0] first_type;
    logic [CLEN_W-1:0]  first_len;
    logic               next_chunk_valid;
    logic [CTYPE_W-1:0] second_type;
  } in_req_t;

  // Result of one step
  typedef struct packed {
    logic             status;
    state_t           new_state;
    logic             state_changed;
    act_t             activity_change;
    logic [TMO_W-1:0] timeout_seconds;
  } out_res_t;

  // Timeout registers
  typedef struct packed {
    logic [TMO_W-1:0] tmo_none;
    logic [TMO_W-1:0] tmo_short;
    logic [TMO_W-1:0] tmo_established;
    logic [TMO_W-1:0] tmo_default;
  } cfg_t;

  // Transition tables indexed [direction][event][current state]
  localparam state_t TRANS [3][10][14] = '{
    '{
      '{S_EST, S_IN1, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_IN1, S_INI, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_INI, S_INI},
      '{S_CWT, S_CWT, S_CWT, S_CSN, S_CRP, S_COK, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_CRP, S_INI, S_INI, S_CRP, S_CRP, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_EST, S_IN1, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_EST, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_SRC, S_IN1, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_SRC, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_CLS, S_INI, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_EST, S_CLS, S_SRC, S_CLS, S_REJ, S_CLS},
      '{S_CLS, S_CLS, S_CLS, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_CLS, S_REJ, S_CLS},
      '{S_CLS, S_IN1, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CLS, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_REJ, S_CLS,
        S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_CLS}
    },
    '{
      '{S_EST, S_IN1, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_CWT, S_CWT, S_CWT, S_CWT, S_CWT, S_CWT, S_CWT,
        S_CWT, S_EST, S_CWT, S_CWT, S_CWT, S_CWT, S_CWT},
      '{S_CSN, S_CSN, S_CSN, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_CEC, S_CEC, S_CEC, S_CEC, S_CEC, S_CEC, S_CEC,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_EST, S_EST, S_EST, S_EST, S_EST, S_EST, S_EST,
        S_EST, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_SSN, S_SSN, S_SSN, S_SSN, S_SSN, S_SSN, S_SSN,
        S_SSN, S_SSN, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_SAS, S_SAS, S_SAS, S_SAS, S_SAS, S_CWT, S_COK,
        S_CEC, S_EST, S_SAS, S_SAS, S_SAS, S_REJ, S_CLS},
      '{S_CLS, S_IN1, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_CLS, S_REJ, S_CLS, S_CLS, S_CLS, S_CLS, S_CLS,
        S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_CLS}
    },
    '{
      '{S_EST, S_IN1, S_INI, S_CSN, S_CRP, S_EST, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_IN1, S_INI, S_INI, S_INI, S_INI, S_INI, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_INI, S_INI},
      '{S_CEC, S_CEC, S_CEC, S_CEC, S_CEC, S_CEC, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_EST, S_EST, S_EST, S_EST, S_EST, S_EST, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_EST, S_IN1, S_INI, S_EST, S_EST, S_CWT, S_EST,
        S_EST, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_SRC, S_IN1, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_SRC, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_CLS, S_INI, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_CLS, S_CLS, S_SRC, S_CLS, S_REJ, S_CLS},
      '{S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_CLS, S_CLS, S_REJ, S_CLS},
      '{S_CLS, S_IN1, S_INI, S_CSN, S_CRP, S_CWT, S_COK,
        S_CEC, S_EST, S_SSN, S_SRC, S_SAS, S_REJ, S_CLS},
      '{S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_REJ, S_CLS,
        S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_CLS, S_CLS}
    }
  };

  // Chunk type byte to event; unknown types count as data
  function automatic event_t chunk_event(logic [CTYPE_W-1:0] ct);
    event_t ev;
    case (ct)
      CT_INIT:              ev = EV_INIT;
      CT_INIT_ACK:          ev = EV_INIT_ACK;
      CT_ABORT:             ev = EV_ABORT;
      CT_SHUTDOWN:          ev = EV_SHUTDOWN;
      CT_SHUTDOWN_ACK:      ev = EV_SHUTDOWN_ACK;
      CT_ERROR:             ev = EV_ERROR;
      CT_COOKIE_ECHO:       ev = EV_COOKIE_ECHO;
      CT_COOKIE_ACK:        ev = EV_COOKIE_ACK;
      CT_SHUTDOWN_COMPLETE: ev = EV_SHUTDOWN_COMPLETE;
      default:              ev = EV_DATA;
    endcase
    return ev;
  endfunction

endpackage

### design/sct_in_if.sv
interface sct_in_if import sct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   conn_index;
  logic               start_new;
  logic [DIR_W-1:0]   direction;
  logic               chunk_valid;
  logic [CTYPE_W-1:0] first_type;
  logic [CLEN_W-1:0]  first_len;
  logic               next_chunk_valid;
  logic [CTYPE_W-1:0] second_type;

  modport source (
    output valid, conn_index, start_new, direction, chunk_valid, first_type,
           first_len, next_chunk_valid, second_type,
    input  ready
  );

  modport sink (
    input  valid, conn_index, start_new, direction, chunk_valid, first_type,
           first_len, next_chunk_valid, second_type,
    output ready
  );
endinterface

### design/sct_out_if.sv
interface sct_out_if import sct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [3:0]       new_state;
  logic             state_changed;
  logic [1:0]       activity_change;
  logic [TMO_W-1:0] timeout_seconds;

  modport source (
    output valid, status, new_state, state_changed, activity_change,
           timeout_seconds,
    input  ready
  );

  modport sink (
    input  valid, status, new_state, state_changed, activity_change,
           timeout_seconds,
    output ready
  );
endinterface

### design/sct_state_mem.sv
module sct_state_mem import sct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  output logic              clear_busy
);

  entry_t            mem [CONN_ENTRIES];
  entry_t            rd_data_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  entry_t            mem_wd;

  // Clearing sweep after reset, one entry per cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(CONN_ENTRIES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Write port shared by sweep and updates
  always_comb begin
    mem_we = wr_en;
    mem_wa = wr_addr;
    mem_wd = wr_data;
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = entry_t'('0);
    end
  end

  // Storage, registered read (old data on same-edge write)
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign clear_busy = clr_busy_r;

endmodule

### design/sct_step_logic.sv
module sct_step_logic import sct_pkg::*; (
  input  in_req_t  req,
  input  entry_t   cur_entry,
  input  cfg_t     cfg,
  output out_res_t res,
  output entry_t   new_entry
);

  entry_t             base;
  state_t             cur;
  state_t             nxt;
  logic               invalid;
  logic               bundle_abort;
  logic [CTYPE_W-1:0] ctype;
  event_t             ev;
  logic [1:0]         dir_sel;
  logic               changed;

  always_comb begin
    // start_new clears the entry before the step
    base = cur_entry;
    if (req.start_new) begin
      base.inactive = 1'b0;
      base.st       = S_NON;
    end
    cur = (base.st > S_CLS) ? S_CLS : base.st;

    invalid = !req.chunk_valid || (req.direction == DIR_UNUSED);

    // cookie chunk of at least BUNDLE_MIN_LEN bundled with a following abort counts as abort
    bundle_abort = ((req.first_type == CT_COOKIE_ECHO) ||
                    (req.first_type == CT_COOKIE_ACK)) &&
                   (req.first_len >= BUNDLE_MIN_LEN) &&
                   req.next_chunk_valid && (req.second_type == CT_ABORT);
    ctype = bundle_abort ? CT_ABORT : req.first_type;
    ev    = chunk_event(ctype);

    dir_sel = invalid ? DIR_IN : req.direction;
    nxt     = TRANS[dir_sel][ev][cur];
    changed = (nxt != cur);

    new_entry     = base;
    res.status    = 1'b0;
    res.new_state = nxt;
    res.state_changed   = changed;
    res.activity_change = ACT_NONE;

    case (nxt)
      S_NON:        res.timeout_seconds = cfg.tmo_none;
      S_IN1, S_REJ: res.timeout_seconds = cfg.tmo_short;
      S_EST:        res.timeout_seconds = cfg.tmo_established;
      default:      res.timeout_seconds = cfg.tmo_default;
    endcase

    if (invalid) begin
      new_entry.st        = cur;
      res.status          = 1'b1;
      res.new_state       = cur;
      res.state_changed   = 1'b0;
      res.timeout_seconds = '0;
    end else if (changed) begin
      // activity flips only on a state change
      new_entry.st = nxt;
      if (!base.inactive && (nxt != S_EST)) begin
        new_entry.inactive  = 1'b1;
        res.activity_change = ACT_INACTIVE;
      end else if (base.inactive && (nxt == S_EST)) begin
        new_entry.inactive  = 1'b0;
        res.activity_change = ACT_ACTIVE;
      end
    end else begin
      new_entry.st = cur;
    end
  end

endmodule

### design/sctp_conn_state_tracker.sv
// SCTP association state tracker.
// in_ch carries one request per packet: connection index, start_new,
// direction and the first/second chunk headers. out_ch returns one result
// per request, in order: status, new state, state change flag, activity
// change and the idle timeout for the new state.
// cfg_we/cfg_index/cfg_data write the four timeout registers; write them
// only while no request is in flight.
// Pipeline: an accepted request waits in the lookup stage (s1_req_r and the
// memory's registered read), then moves into the result register, raising
// out_ch.valid, once that register is empty or being taken. Throughput: one
// request per cycle while out_ch.ready is high, set by the state memory's
// registered read and separate write port plus one-entry write forwarding.
// Reset: timeouts return to 2/4/900/61 s; a sweep clears all CONN_ENTRIES
// state memory entries, one per cycle, and in_ch.ready stays low meanwhile.
// Stall: while out_ch.ready is low the result register holds; one more
// request can still be accepted into the lookup stage, then in_ch.ready
// drops until the result is taken.
module sctp_conn_state_tracker import sct_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  sct_in_if.sink             in_ch,
  sct_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [TMO_W-1:0]   cfg_data
);

  cfg_t              cfg_r;
  in_req_t           s1_req_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  entry_t            fwd_entry_r;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r;

  logic              clear_busy;
  logic              in_fire;
  logic              s1_move;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] s1_addr;
  entry_t            rd_data;
  entry_t            cur_entry;
  out_res_t          step_res;
  entry_t            step_entry;
  in_req_t           in_req;

  // Timeout registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tmo_none        <= TMO_NONE_RST;
      cfg_r.tmo_short       <= TMO_SHORT_RST;
      cfg_r.tmo_established <= TMO_ESTABLISHED_RST;
      cfg_r.tmo_default     <= TMO_DEFAULT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT_NONE:        cfg_r.tmo_none        <= cfg_data;
        CFG_TIMEOUT_SHORT:       cfg_r.tmo_short       <= cfg_data;
        CFG_TIMEOUT_ESTABLISHED: cfg_r.tmo_established <= cfg_data;
        CFG_TIMEOUT_DEFAULT:     cfg_r.tmo_default     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and stage advance
  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !clear_busy && (!s1_valid_r || s1_move);
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_req.conn_index       = in_ch.conn_index;
    in_req.start_new        = in_ch.start_new;
    in_req.direction        = in_ch.direction;
    in_req.chunk_valid      = in_ch.chunk_valid;
    in_req.first_type       = in_ch.first_type;
    in_req.first_len        = in_ch.first_len;
    in_req.next_chunk_valid = in_ch.next_chunk_valid;
    in_req.second_type      = in_ch.second_type;
  end

  assign in_addr = ADDR_W'(in_ch.conn_index);
  assign s1_addr = ADDR_W'(s1_req_r.conn_index);

  sct_state_mem u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_fire),
    .rd_addr    (in_addr),
    .rd_data    (rd_data),
    .wr_en      (s1_move),
    .wr_addr    (s1_addr),
    .wr_data    (step_entry),
    .clear_busy (clear_busy)
  );

  // Forward the last write over the stale memory read
  assign cur_entry = (fwd_valid_r && (fwd_addr_r == s1_addr)) ? fwd_entry_r : rd_data;

  sct_step_logic u_step (
    .req       (s1_req_r),
    .cur_entry (cur_entry),
    .cfg       (cfg_r),
    .res       (step_res),
    .new_entry (step_entry)
  );

  // Lookup stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_move) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_req;
    end
    if (s1_move) begin
      fwd_addr_r  <= s1_addr;
      fwd_entry_r <= step_entry;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_res_r.status;
  assign out_ch.new_state       = out_res_r.new_state;
  assign out_ch.state_changed   = out_res_r.state_changed;
  assign out_ch.activity_change = out_res_r.activity_change;
  assign out_ch.timeout_seconds = out_res_r.timeout_seconds;

  // Checks
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_ch.ready)
    else $error("request accepted during memory sweep");

  a_act_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.activity_change != ACT_NONE)) |-> out_ch.state_changed)
    else $error("activity change without state change");

  a_active_is_est: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.activity_change == ACT_ACTIVE)) |->
    (out_ch.new_state == S_EST))
    else $error("entry became active outside ESTABLISHED");

  a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status) |->
    (!out_ch.state_changed && (out_ch.timeout_seconds == '0)))
    else $error("invalid packet reported a state change");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_ch.valid)
    else $error("processed request lost before result register");

endmodule

### verif/sct_track_sb_pkg.sv
`timescale 1ns / 1ps

package sct_track_sb_pkg;
  import sct_pkg::*;

  class conn_state_scoreboard;
    // Next state per [direction][event]; one hex digit per current state
    string next_rows [3][10];
    // Event code per chunk type byte 0..14, one hex digit each
    string event_of_type;

    state_t           conn_st [CONN_ENTRIES];
    bit               idle_flag [CONN_ENTRIES];
    logic [TMO_W-1:0] tmo_none, tmo_short, tmo_est, tmo_def;
    out_res_t         expected_q [$];
    int               mismatches;
    int               checked;
    int               act_changes;
    bit [13:0]        states_seen;

    function new();
      next_rows = '{
        '{"8123456789abcd", "1223456789ab22", "5553466789abcd", "4224456789abcd",
          "8123456889abcd", "a1234567a9abcd", "d22345678dadcd", "ddd3456789adcd",
          "d123456d89abcd", "dddddcdddddddd"},
        '{"8123456789abcd", "55555555855555", "3333456789abcd", "7777777789abcd",
          "8888888889abcd", "9999999999abcd", "bbbbb5678bbbcd", "d123456789abcd",
          "ddddd56789abcd", "dcdddddddddddd"},
        '{"8123486789abcd", "1222226789ab22", "7777776789abcd", "8888886789abcd",
          "8128858889abcd", "a1234567a9abcd", "d2234567ddadcd", "ddddd56789ddcd",
          "d123456789abcd", "dddddcdddddddd"}
      };
      event_of_type = "012000956834007";
      for (int i = 0; i < CONN_ENTRIES; i++) begin
        conn_st[i]   = S_NON;
        idle_flag[i] = 1'b0;
      end
      tmo_none    = 16'd2;
      tmo_short   = 16'd4;
      tmo_est     = 16'd900;
      tmo_def     = 16'd61;
      mismatches  = 0;
      checked     = 0;
      act_changes = 0;
      states_seen = '0;
    endfunction

    static function int hex_at(string s, int pos);
      int c;
      c = s.getc(pos);
      return (c >= 8'h61) ? c - 8'h61 + 10 : c - 8'h30;
    endfunction

    function void set_timeout(logic [CFG_IW-1:0] idx, logic [TMO_W-1:0] val);
      case (idx)
        CFG_TIMEOUT_NONE:        tmo_none  = val;
        CFG_TIMEOUT_SHORT:       tmo_short = val;
        CFG_TIMEOUT_ESTABLISHED: tmo_est   = val;
        CFG_TIMEOUT_DEFAULT:     tmo_def   = val;
        default: ;
      endcase
    endfunction

    function logic [TMO_W-1:0] idle_timeout(state_t st);
      case (st)
        S_NON:        return tmo_none;
        S_IN1, S_REJ: return tmo_short;
        S_EST:        return tmo_est;
        default:      return tmo_def;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the connection entry for one accepted request
    function void note_request(in_req_t r);
      int                 idx;
      state_t             cur;
      state_t             nxt;
      event_t             ev;
      logic [CTYPE_W-1:0] ct;
      out_res_t           e;
      idx = int'(r.conn_index) % CONN_ENTRIES;
      if (r.start_new) begin
        conn_st[idx]   = S_NON;
        idle_flag[idx] = 1'b0;
      end
      cur = conn_st[idx];

      // no chunk or unused direction: report stored state, nothing moves
      if (!r.chunk_valid || r.direction == DIR_UNUSED) begin
        e.status          = 1'b1;
        e.new_state       = cur;
        e.state_changed   = 1'b0;
        e.activity_change = ACT_NONE;
        e.timeout_seconds = '0;
        expected_q.push_back(e);
        return;
      end

      // cookie chunk of at least BUNDLE_MIN_LEN with an abort bundled behind it counts as abort
      ct = r.first_type;
      if ((ct == CT_COOKIE_ECHO || ct == CT_COOKIE_ACK) &&
          r.first_len >= BUNDLE_MIN_LEN && r.next_chunk_valid &&
          r.second_type == CT_ABORT)
        ct = CT_ABORT;
      ev  = (ct < 15) ? event_t'(hex_at(event_of_type, ct)) : EV_DATA;
      nxt = state_t'(hex_at(next_rows[r.direction][ev], cur));

      e.status          = 1'b0;
      e.new_state       = nxt;
      e.state_changed   = (nxt != cur);
      e.activity_change = ACT_NONE;
      if (nxt != cur) begin
        if (!idle_flag[idx] && nxt != S_EST) begin
          idle_flag[idx]    = 1'b1;
          e.activity_change = ACT_INACTIVE;
        end else if (idle_flag[idx] && nxt == S_EST) begin
          idle_flag[idx]    = 1'b0;
          e.activity_change = ACT_ACTIVE;
        end
        conn_st[idx] = nxt;
      end
      e.timeout_seconds = idle_timeout(nxt);
      states_seen[nxt] = 1'b1;
      if (e.activity_change != ACT_NONE) act_changes++;
      expected_q.push_back(e);
    endfunction

    // Compare one delivered result against the oldest prediction
    function void check_result(out_res_t got);
      out_res_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH %0d: result with no request waiting (state=%0d)",
                   mismatches, got.new_state);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.status !== e.status || got.new_state !== e.new_state ||
          got.state_changed !== e.state_changed ||
          got.activity_change !== e.activity_change ||
          got.timeout_seconds !== e.timeout_seconds) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("MISMATCH %0d on result %0d:", mismatches, checked);
          $display("  expected status=%0b state=%0d changed=%0b act=%0d tmo=%0d",
                   e.status, e.new_state, e.state_changed, e.activity_change,
                   e.timeout_seconds);
          $display("  actual   status=%0b state=%0d changed=%0b act=%0d tmo=%0d",
                   got.status, got.new_state, got.state_changed,
                   got.activity_change, got.timeout_seconds);
        end
      end
    endfunction
  endclass

endpackage

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import sct_pkg::*;
  import sct_track_sb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [CTYPE_W-1:0] CT_DATA = 8'd0;
  localparam logic [CTYPE_W-1:0] KNOWN_TYPES [10] = '{
    CT_DATA, CT_INIT, CT_INIT_ACK, CT_ABORT, CT_SHUTDOWN, CT_SHUTDOWN_ACK,
    CT_ERROR, CT_COOKIE_ECHO, CT_COOKIE_ACK, CT_SHUTDOWN_COMPLETE
  };
  // Normal association life cycle, one chunk per packet
  localparam logic [CTYPE_W-1:0] ASSOC_SCRIPT [9] = '{
    CT_INIT, CT_INIT_ACK, CT_COOKIE_ECHO, CT_COOKIE_ACK, CT_DATA, CT_DATA,
    CT_SHUTDOWN, CT_SHUTDOWN_ACK, CT_SHUTDOWN_COMPLETE
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [TMO_W-1:0]  cfg_data;

  sct_in_if  in_ch ();
  sct_out_if out_ch ();

  sctp_conn_state_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  conn_state_scoreboard sb;
  out_res_t             got_res;
  logic [IDX_W-1:0]     conn_pool [8];
  bit                   src_idle_on;
  bit                   sink_idle_on;
  int                   n_sent;
  int                   n_settings;
  int                   cycle_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result sink with random backpressure bursts
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_res = out_res_t'({out_ch.status, out_ch.new_state, out_ch.state_changed,
                            out_ch.activity_change, out_ch.timeout_seconds});
      sb.check_result(got_res);
    end
  end

  function automatic logic [CLEN_W-1:0] rand_len();
    return ($urandom_range(0, 3) == 0) ? CLEN_W'($urandom_range(0, 7))
                                       : CLEN_W'($urandom_range(0, 65535));
  endfunction

  function automatic in_req_t mk(int idx, bit sn, logic [DIR_W-1:0] dir, bit cv,
                                 logic [CTYPE_W-1:0] ct, int len, bit ncv,
                                 logic [CTYPE_W-1:0] nct);
    in_req_t r;
    r.conn_index       = IDX_W'(idx);
    r.start_new        = sn;
    r.direction        = dir;
    r.chunk_valid      = cv;
    r.first_type       = ct;
    r.first_len        = CLEN_W'(len);
    r.next_chunk_valid = ncv;
    r.second_type      = nct;
    return r;
  endfunction

  function automatic in_req_t noise_request();
    in_req_t r;
    r.conn_index       = IDX_W'($urandom_range(0, 1023));
    r.start_new        = ($urandom_range(0, 9) == 0);
    r.direction        = DIR_W'($urandom_range(0, 3));
    r.chunk_valid      = ($urandom_range(0, 9) != 0);
    r.first_type       = ($urandom_range(0, 1) == 0) ? KNOWN_TYPES[$urandom_range(0, 9)]
                                                     : CTYPE_W'($urandom_range(0, 255));
    r.first_len        = rand_len();
    r.next_chunk_valid = 1'($urandom_range(0, 1));
    r.second_type      = ($urandom_range(0, 1) == 0) ? CT_ABORT
                                                     : CTYPE_W'($urandom_range(0, 255));
    return r;
  endfunction

  // Present one request, with an optional gap before it, until accepted
  task automatic push_request(input in_req_t r);
    int gap;
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid            <= 1'b1;
    in_ch.conn_index       <= r.conn_index;
    in_ch.start_new        <= r.start_new;
    in_ch.direction        <= r.direction;
    in_ch.chunk_valid      <= r.chunk_valid;
    in_ch.first_type       <= r.first_type;
    in_ch.first_len        <= r.first_len;
    in_ch.next_chunk_valid <= r.next_chunk_valid;
    in_ch.second_type      <= r.second_type;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(r);
    n_sent++;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_timeouts(input logic [TMO_W-1:0] t_none, t_short,
                                  t_est, t_def);
    logic [CFG_IW-1:0] regs [4];
    logic [TMO_W-1:0]  vals [4];
    regs = '{CFG_TIMEOUT_NONE, CFG_TIMEOUT_SHORT, CFG_TIMEOUT_ESTABLISHED,
             CFG_TIMEOUT_DEFAULT};
    vals = '{t_none, t_short, t_est, t_def};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      sb.set_timeout(regs[i], vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // One association on a pooled connection, with mutations and early cuts
  task automatic send_flow(inout int cnt, input int limit);
    logic [IDX_W-1:0]   idx;
    logic [DIR_W-1:0]   base;
    logic [CTYPE_W-1:0] ct;
    int                 steps;
    in_req_t            r;
    idx   = conn_pool[$urandom_range(0, 7)];
    base  = ($urandom_range(0, 2) == 0) ? DIR_IN_ONLY
          : (($urandom_range(0, 1) == 0) ? DIR_IN : DIR_OUT);
    steps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 9;
    for (int k = 0; k < steps && cnt < limit; k++) begin
      ct = ASSOC_SCRIPT[k];
      if (ct == CT_DATA && $urandom_range(0, 2) == 0)
        ct = CTYPE_W'($urandom_range(15, 255));
      case ($urandom_range(0, 19))
        0: ct = CT_ABORT;
        1: ct = CTYPE_W'($urandom_range(0, 255));
        2: ct = KNOWN_TYPES[$urandom_range(0, 9)];
        default: ;
      endcase
      r.conn_index = idx;
      r.start_new  = (k == 0) && ($urandom_range(0, 9) < 6);
      if (base == DIR_IN_ONLY || k % 2 == 0)
        r.direction = base;
      else
        r.direction = (base == DIR_IN) ? DIR_OUT : DIR_IN;
      r.chunk_valid = ($urandom_range(0, 49) != 0);
      r.first_type  = ct;
      r.first_len   = rand_len();
      if ((ct == CT_COOKIE_ECHO || ct == CT_COOKIE_ACK) && $urandom_range(0, 4) == 0) begin
        r.next_chunk_valid = 1'b1;
        r.second_type      = CT_ABORT;
      end else begin
        r.next_chunk_valid = 1'($urandom_range(0, 1));
        r.second_type      = CTYPE_W'($urandom_range(0, 255));
      end
      push_request(r);
      cnt++;
    end
  endtask

  task automatic run_traffic(input int n);
    int      cnt;
    in_req_t r;
    cnt = 0;
    for (int i = 0; i < 8; i++) conn_pool[i] = IDX_W'($urandom_range(0, 1023));
    while (cnt < n) begin
      if ($urandom_range(0, 99) < 70) begin
        send_flow(cnt, n);
      end else begin
        r = noise_request();
        push_request(r);
        cnt++;
      end
    end
  endtask

  initial begin
    sb                     = new();
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_TIMEOUT_NONE;
    cfg_data               = '0;
    in_ch.valid            = 1'b0;
    in_ch.conn_index       = '0;
    in_ch.start_new        = 1'b0;
    in_ch.direction        = DIR_IN;
    in_ch.chunk_valid      = 1'b0;
    in_ch.first_type       = '0;
    in_ch.first_len        = '0;
    in_ch.next_chunk_valid = 1'b0;
    in_ch.second_type      = '0;
    src_idle_on            = 1'b1;
    sink_idle_on           = 1'b1;
    n_sent                 = 0;
    n_settings             = 0;
    cycle_count            = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset timeouts
    push_request(mk(0, 0, DIR_IN, 0, 8'hFF, 65535, 1, 8'hFF));       // no chunk
    push_request(mk(1023, 0, DIR_UNUSED, 1, CT_INIT, 20, 0, 0));      // unused dir
    push_request(mk(1023, 1, DIR_UNUSED, 0, CT_INIT, 20, 0, 0));
    push_request(mk(1023, 1, DIR_OUT, 1, CT_INIT, 20, 0, 0));
    push_request(mk(1023, 0, DIR_IN, 1, CT_INIT_ACK, 20, 0, 0));
    push_request(mk(1023, 0, DIR_OUT, 1, CT_COOKIE_ECHO, 3, 1, CT_ABORT)); // too short
    push_request(mk(1023, 0, DIR_IN, 1, CT_COOKIE_ACK, 4, 0, CT_ABORT));
    push_request(mk(1023, 0, DIR_IN, 1, CT_DATA, 0, 0, 0));
    push_request(mk(1023, 0, DIR_IN, 1, 8'd15, 100, 0, 0));          // unknown type
    push_request(mk(1023, 0, DIR_OUT, 1, 8'hFF, 100, 1, 8'hFF));
    push_request(mk(1023, 0, DIR_IN, 1, CT_ERROR, 8, 0, 0));
    push_request(mk(1023, 0, DIR_IN, 1, CT_SHUTDOWN, 8, 0, 0));
    push_request(mk(1023, 0, DIR_OUT, 1, CT_SHUTDOWN_ACK, 4, 0, 0));
    push_request(mk(1023, 0, DIR_IN, 1, CT_SHUTDOWN_COMPLETE, 4, 0, 0));
    push_request(mk(1023, 0, DIR_IN, 1, CT_INIT, 20, 0, 0));
    push_request(mk(0, 0, DIR_IN_ONLY, 1, CT_INIT, 20, 0, 0));
    push_request(mk(0, 0, DIR_IN_ONLY, 1, CT_COOKIE_ECHO, 4, 1, CT_ABORT)); // bundled
    push_request(mk(0, 1, DIR_IN_ONLY, 1, CT_COOKIE_ACK, 65535, 1, CT_ABORT));
    push_request(mk(0, 1, DIR_OUT, 1, CT_ABORT, 0, 0, 0));
    push_request(mk(2, 0, DIR_OUT, 1, CT_INIT, 20, 0, 0));
    push_request(mk(2, 0, DIR_IN, 1, CT_ABORT, 4, 0, 0));
    push_request(mk(2, 0, DIR_IN, 1, CT_INIT, 20, 0, 0));
    push_request(mk(3, 0, DIR_OUT, 1, CT_COOKIE_ACK, 4, 1, CT_SHUTDOWN));
    push_request(mk(3, 0, DIR_IN, 1, CT_SHUTDOWN, 8, 0, 0));

    // Random phases, each under the last timeout setting programmed before it
    drain();
    program_timeouts(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_traffic(260);
    drain();
    program_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(260);
    drain();
    program_timeouts(TMO_W'($urandom_range(0, 65535)), TMO_W'($urandom_range(0, 65535)),
                     TMO_W'($urandom_range(0, 65535)), TMO_W'($urandom_range(0, 65535)));
    run_traffic(130);
    drain();  // sender holds until every result is back
    run_traffic(130);
    drain();
    program_timeouts(16'h0000, 16'hFFFF, TMO_W'($urandom_range(0, 65535)), 16'h0001);
    run_traffic(260);
    drain();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    program_timeouts(TMO_W'($urandom_range(0, 65535)), TMO_W'($urandom_range(0, 65535)),
                     TMO_W'($urandom_range(0, 65535)), TMO_W'($urandom_range(0, 65535)));
    run_traffic(260);
    drain();

    $display("Covered %0d requests, %0d results checked, %0d timeout settings",
             n_sent, sb.checked, n_settings);
    $display("Reached %0d of 14 association states with %0d activity changes",
             $countones(sb.states_seen), sb.act_changes);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never delivered",
               sb.mismatches, sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
